// File: rtl/ssea_pkg.sv
// Shared types and default sizes for the sorted sparse error accumulator.
package ssea_pkg;

   // Default sizes handed to the top-level parameters
   localparam int DEF_CAPACITY     = 64;
   localparam int DEF_OFFSET_BITS  = 16;
   localparam int DEF_PATTERN_BITS = 32;

   // Outcome of one word
   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_MERGED    = 2'd1,
      ST_CANCELLED = 2'd2,
      ST_DROPPED   = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_CMP,
      S_DEC,
      S_MRD,
      S_MWR,
      S_PUT,
      S_DONE
   } state_type;

endpackage

// File: rtl/ssea_if.sv
// Request and response channel interfaces (valid/ready).
interface ssea_req_if #(
   parameter int OFFSET_BITS  = 16,
   parameter int PATTERN_BITS = 32
) ();
   logic                    valid;
   logic                    ready;
   logic [OFFSET_BITS-1:0]  offset;
   logic [PATTERN_BITS-1:0] err_bits;

   modport source (output valid, offset, err_bits, input ready);
   modport sink   (input valid, offset, err_bits, output ready);
endinterface

interface ssea_rsp_if import ssea_pkg::*; #(
   parameter int CNT_BITS     = 7,
   parameter int PATTERN_BITS = 32
) ();
   logic                    valid;
   logic                    ready;
   status_type              status;
   logic [CNT_BITS-1:0]     position;
   logic [CNT_BITS-1:0]     entry_count;
   logic [PATTERN_BITS-1:0] pattern_now;

   modport source (output valid, status, position, entry_count, pattern_now, input ready);
   modport sink   (input valid, status, position, entry_count, pattern_now, output ready);
endinterface

// File: rtl/ssea_mem.sv
// Table storage: one write port, one read port with registered read data.
module ssea_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered and valid in the cycle after the address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ssea_seq.sv
// Sequencer: linear search, merge decision and table shifts one entry at a time.
module ssea_seq import ssea_pkg::*; #(
   parameter int CAPACITY     = DEF_CAPACITY,
   parameter int OFFSET_BITS  = DEF_OFFSET_BITS,
   parameter int PATTERN_BITS = DEF_PATTERN_BITS,
   parameter int CNT_BITS     = $clog2(CAPACITY + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   // request side
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OFFSET_BITS-1:0]  req_offset,
   input  logic [PATTERN_BITS-1:0] req_pattern,
   // result side
   output logic                    done_valid,
   input  logic                    done_ready,
   output status_type              done_status,
   output logic [CNT_BITS-1:0]     done_position,
   output logic [CNT_BITS-1:0]     done_count,
   output logic [PATTERN_BITS-1:0] done_pattern
);

   localparam int AW = $clog2(CAPACITY);
   localparam int EW = OFFSET_BITS + PATTERN_BITS;

   // memory port signals
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data;

   ssea_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;        // stored entries
   logic [CNT_BITS-1:0]     res_cnt_ff, res_cnt_in; // count after this word
   logic [CNT_BITS-1:0]     cur_ff, cur_in;        // scan / shift cursor
   logic [CNT_BITS-1:0]     pos_ff, pos_in;
   logic                    found_ff, found_in;
   logic                    up_ff, up_in;          // shift direction: 1 = open a gap
   logic [OFFSET_BITS-1:0]  off_ff, off_in;
   logic [PATTERN_BITS-1:0] pat_ff, pat_in;
   logic [PATTERN_BITS-1:0] stored_ff, stored_in;
   logic [PATTERN_BITS-1:0] now_ff, now_in;
   status_type              status_ff, status_in;

   logic [OFFSET_BITS-1:0]  rd_off;
   logic [PATTERN_BITS-1:0] rd_pat;
   logic [PATTERN_BITS-1:0] merged;
   logic [CNT_BITS-1:0]     cur_step;
   logic [CNT_BITS-1:0]     cur_prev;

   assign rd_off   = rd_data[EW-1 -: OFFSET_BITS];
   assign rd_pat   = rd_data[PATTERN_BITS-1:0];
   assign merged   = stored_ff ^ pat_ff;
   // shared cursor adder: down while opening a gap, up otherwise
   assign cur_step = up_ff ? (cur_ff - CNT_BITS'(1)) : (cur_ff + CNT_BITS'(1));
   assign cur_prev = cur_ff - CNT_BITS'(1);

   // State and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      res_cnt_ff <= res_cnt_in;
      cur_ff     <= cur_in;
      pos_ff     <= pos_in;
      found_ff   <= found_in;
      up_ff      <= up_in;
      off_ff     <= off_in;
      pat_ff     <= pat_in;
      stored_ff  <= stored_in;
      now_ff     <= now_in;
      status_ff  <= status_in;
   end

   // Next state and control
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      res_cnt_in = res_cnt_ff;
      cur_in     = cur_ff;
      pos_in     = pos_ff;
      found_in   = found_ff;
      up_in      = up_ff;
      off_in     = off_ff;
      pat_in     = pat_ff;
      stored_in  = stored_ff;
      now_in     = now_ff;
      status_in  = status_ff;
      req_ready  = 1'b0;
      done_valid = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = pos_ff[AW-1:0];
      wr_data    = {off_ff, pat_ff};
      rd_en      = 1'b0;
      rd_addr    = cur_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               off_in   = req_offset;
               pat_in   = req_pattern;
               cur_in   = '0;
               up_in    = 1'b0;
               pos_in   = '0;
               found_in = 1'b0;
               state_in = (cnt_ff == '0) ? S_DEC : S_RD;
            end
         end

         // scan: read entry at cursor
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_CMP;
         end

         // scan: compare stored offset against the new one
         S_CMP: begin
            if (rd_off < off_ff) begin
               cur_in = cur_step;
               if (cur_step == cnt_ff) begin
                  pos_in   = cnt_ff;
                  found_in = 1'b0;
                  state_in = S_DEC;
               end else begin
                  state_in = S_RD;
               end
            end else begin
               pos_in    = cur_ff;
               found_in  = (rd_off == off_ff);
               stored_in = rd_pat;
               state_in  = S_DEC;
            end
         end

         // choose merge, cancel, insert or drop
         S_DEC: begin
            if (found_ff) begin
               if (merged != '0) begin
                  wr_en      = 1'b1;
                  wr_data    = {off_ff, merged};
                  status_in  = ST_MERGED;
                  now_in     = merged;
                  res_cnt_in = cnt_ff;
                  state_in   = S_DONE;
               end else begin
                  status_in  = ST_CANCELLED;
                  now_in     = '0;
                  res_cnt_in = cnt_ff - CNT_BITS'(1);
                  up_in      = 1'b0;
                  cur_in     = pos_ff + CNT_BITS'(1);
                  state_in   = ((pos_ff + CNT_BITS'(1)) < cnt_ff) ? S_MRD : S_DONE;
               end
            end else if (cnt_ff == CNT_BITS'(CAPACITY)) begin
               status_in  = ST_DROPPED;
               now_in     = '0;
               res_cnt_in = cnt_ff;
               state_in   = S_DONE;
            end else begin
               status_in  = ST_INSERTED;
               now_in     = pat_ff;
               res_cnt_in = cnt_ff + CNT_BITS'(1);
               up_in      = 1'b1;
               cur_in     = cnt_ff;
               state_in   = (cnt_ff > pos_ff) ? S_MRD : S_PUT;
            end
         end

         // shift: read source entry
         S_MRD: begin
            rd_en    = 1'b1;
            rd_addr  = up_ff ? cur_prev[AW-1:0] : cur_ff[AW-1:0];
            state_in = S_MWR;
         end

         // shift: write it one place up or down
         S_MWR: begin
            wr_en   = 1'b1;
            wr_addr = up_ff ? cur_ff[AW-1:0] : cur_prev[AW-1:0];
            wr_data = rd_data;
            cur_in  = cur_step;
            if (up_ff) begin
               state_in = (cur_step > pos_ff) ? S_MRD : S_PUT;
            end else begin
               state_in = (cur_step < cnt_ff) ? S_MRD : S_DONE;
            end
         end

         // drop the new pair into the gap
         S_PUT: begin
            wr_en    = 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               cnt_in   = res_cnt_ff;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign done_status   = status_ff;
   assign done_position = pos_ff;
   assign done_count    = res_cnt_ff;
   assign done_pattern  = now_ff;

endmodule

// File: rtl/sorted_sparse_error_accumulator_top.sv
// Top level of the sorted sparse error accumulator with its response register.
//
// Keeps a table of (offset, pattern) pairs sorted by offset. A request word
// carries an offset and an error pattern; the pattern is XORed into a stored
// entry with the same offset (removing it when the result is zero), or the
// pair is inserted at its sorted place, or it is dropped when the table is full.
// Every request gives exactly one response word: status, sorted position,
// entry count after the step and the pattern now stored at that offset.
//
// Operation: the table lives in a memory with one registered read port, so one
// sequencer walks it an entry at a time. After a request is taken it reads and
// compares each stored entry (those below its offset and the first one at or
// above it), then decides, then moves entries one at a time with a read and a
// write on an insert or removal, writes an inserted pair, and hands the result
// to the response register, which shows it the cycle after. The next request is
// taken in the cycle that follows. req_chan.ready is high only while the
// sequencer is idle.
// Reset (synchronous) empties the table at once; no clearing pass is needed.
// The response register holds a finished word while the receiver stalls, and a
// new request may already be taken and worked on in that time.
module sorted_sparse_error_accumulator_top import ssea_pkg::*; #(
   parameter int CAPACITY     = DEF_CAPACITY,
   parameter int OFFSET_BITS  = DEF_OFFSET_BITS,
   parameter int PATTERN_BITS = DEF_PATTERN_BITS
) (
   input  logic      clock,
   input  logic      reset,
   ssea_req_if.sink   req_chan,
   ssea_rsp_if.source rsp_chan
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   logic                    done_valid;
   logic                    done_ready;
   status_type              done_status;
   logic [CNT_BITS-1:0]     done_position;
   logic [CNT_BITS-1:0]     done_count;
   logic [PATTERN_BITS-1:0] done_pattern;

   ssea_seq #(
      .CAPACITY     (CAPACITY),
      .OFFSET_BITS  (OFFSET_BITS),
      .PATTERN_BITS (PATTERN_BITS),
      .CNT_BITS     (CNT_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_offset    (req_chan.offset),
      .req_pattern   (req_chan.err_bits),
      .done_valid    (done_valid),
      .done_ready    (done_ready),
      .done_status   (done_status),
      .done_position (done_position),
      .done_count    (done_count),
      .done_pattern  (done_pattern)
   );

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [CNT_BITS-1:0]     rsp_position_ff;
   logic [CNT_BITS-1:0]     rsp_count_ff;
   logic [PATTERN_BITS-1:0] rsp_pattern_ff;

   // response slot is free when empty or being drained this cycle
   assign done_ready = !rsp_valid_ff || rsp_chan.ready;

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_ready) begin
         rsp_valid_ff <= done_valid;
      end
      if (done_ready && done_valid) begin
         rsp_status_ff   <= done_status;
         rsp_position_ff <= done_position;
         rsp_count_ff    <= done_count;
         rsp_pattern_ff  <= done_pattern;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.position    = rsp_position_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.pattern_now = rsp_pattern_ff;

endmodule
